// ===== design/frs_pkg.sv =====
`default_nettype none
package frs_pkg;

	localparam int FRS_MAX_FRAME   = 512;
	localparam int FRS_SEQ_MODULUS = 64;
	localparam int SEQ_W           = 6;

	localparam logic [1:0] FUNC_PUSH  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_RESET = 2'd2;

	localparam logic [1:0] ST_COMPLETE   = 2'd0;
	localparam logic [1:0] ST_INCOMPLETE = 2'd1;
	localparam logic [1:0] ST_ERROR      = 2'd2;
	localparam logic [1:0] ST_READ       = 2'd3;

	localparam logic [7:0] HDR_START = 8'h80;
	localparam logic [7:0] HDR_END   = 8'h40;

	typedef enum logic [1:0] {
		ACT_IDLE,
		ACT_ACCEPT,
		ACT_REJECT
	} act_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       fragment_last;
		logic [8:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] total_len;
		logic [7:0] read_data;
	} out_item_t;

	// result of one accepted item, before the store read data is merged in
	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		logic [9:0] total_len;
		logic       rd_zero;
	} res_t;

endpackage
`default_nettype wire

// ===== design/frs_frame_buf.sv =====
`default_nettype none
module frs_frame_buf
	import frs_pkg::*;
#(
	parameter int DEPTH = FRS_MAX_FRAME,
	parameter int AW    = $clog2(FRS_MAX_FRAME)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [7:0]         rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data until the next read so a stalled reply keeps its byte
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== design/frs_ctrl.sv =====
`default_nettype none
module frs_ctrl
	import frs_pkg::*;
#(
	parameter int MAX_FRAME   = FRS_MAX_FRAME,
	parameter int SEQ_MODULUS = FRS_SEQ_MODULUS,
	parameter int AW          = $clog2(FRS_MAX_FRAME)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire in_item_t      item,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [7:0]         wr_data,
	output res_t               res
);

	localparam int LW = $clog2(MAX_FRAME + 1);

	logic [LW-1:0]    frame_len_q, frame_len_n;
	logic             assembling_q, assembling_n;
	logic [SEQ_W-1:0] exp_seq_q, exp_seq_n;
	logic             in_frag_q, in_frag_n;
	act_t             act_q, act_n;
	logic [LW-1:0]    pay_cnt_q, pay_cnt_n;
	logic             end_seen_q, end_seen_n;
	logic             ovf_q, ovf_n;

	logic [LW:0]      pos;
	logic             room;
	logic [SEQ_W-1:0] hdr_seq;
	logic [SEQ_W-1:0] seq_inc;

	assign pos     = {1'b0, frame_len_q} + {1'b0, pay_cnt_q};
	assign room    = pos < (LW + 1)'(MAX_FRAME);
	assign hdr_seq = item.data_byte[SEQ_W-1:0];
	assign seq_inc = (exp_seq_q == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : exp_seq_q + SEQ_W'(1);

	assign wr_addr = AW'(pos);
	assign wr_data = item.data_byte;

	always_comb begin
		frame_len_n  = frame_len_q;
		assembling_n = assembling_q;
		exp_seq_n    = exp_seq_q;
		in_frag_n    = in_frag_q;
		act_n        = act_q;
		pay_cnt_n    = pay_cnt_q;
		end_seen_n   = end_seen_q;
		ovf_n        = ovf_q;
		wr_en        = 1'b0;
		res          = '0;
		if (accept) begin
			unique case (item.func)
				FUNC_READ: begin
					res.valid   = 1'b1;
					res.status  = ST_READ;
					res.rd_zero = 32'(item.read_index) >= MAX_FRAME;
				end
				FUNC_RESET: begin
					frame_len_n  = '0;
					assembling_n = 1'b0;
					exp_seq_n    = '0;
					in_frag_n    = 1'b0;
					act_n        = ACT_IDLE;
					pay_cnt_n    = '0;
					end_seen_n   = 1'b0;
					ovf_n        = 1'b0;
				end
				FUNC_PUSH: begin
					if (!in_frag_q) begin
						if (item.fragment_last) begin
							// header-only fragment
							frame_len_n  = '0;
							assembling_n = 1'b0;
							exp_seq_n    = '0;
							res.valid    = 1'b1;
							res.status   = ST_ERROR;
						end else begin
							if ((item.data_byte & HDR_START) != '0) begin
								frame_len_n  = '0;
								exp_seq_n    = '0;
								assembling_n = (hdr_seq == '0);
								act_n        = (hdr_seq == '0) ? ACT_ACCEPT : ACT_REJECT;
							end else if (!assembling_q) begin
								act_n = ACT_REJECT;
							end else if (hdr_seq != exp_seq_q) begin
								frame_len_n  = '0;
								assembling_n = 1'b0;
								exp_seq_n    = '0;
								act_n        = ACT_REJECT;
							end else begin
								act_n = ACT_ACCEPT;
							end
							in_frag_n  = 1'b1;
							end_seen_n = (item.data_byte & HDR_END) != '0;
							pay_cnt_n  = '0;
							ovf_n      = 1'b0;
						end
					end else begin
						if (act_q == ACT_ACCEPT && !ovf_q) begin
							if (room) begin
								wr_en     = 1'b1;
								pay_cnt_n = pay_cnt_q + LW'(1);
							end else begin
								ovf_n = 1'b1;
							end
						end
						if (item.fragment_last) begin
							in_frag_n  = 1'b0;
							act_n      = ACT_IDLE;
							res.valid  = 1'b1;
							if (act_q != ACT_ACCEPT || ovf_n) begin
								if (act_q == ACT_ACCEPT) begin
									frame_len_n  = '0;
									assembling_n = 1'b0;
									exp_seq_n    = '0;
								end
								res.status = ST_ERROR;
							end else begin
								frame_len_n = LW'(pos + (LW + 1)'(wr_en));
								exp_seq_n   = seq_inc;
								if (end_seen_q) begin
									assembling_n  = 1'b0;
									res.status    = ST_COMPLETE;
									res.total_len = 10'(pos + (LW + 1)'(wr_en));
								end else begin
									res.status = ST_INCOMPLETE;
								end
							end
						end
					end
				end
				default: begin
					// unused code: ignore
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q  <= '0;
			assembling_q <= 1'b0;
			exp_seq_q    <= '0;
			in_frag_q    <= 1'b0;
			act_q        <= ACT_IDLE;
			pay_cnt_q    <= '0;
			end_seen_q   <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			frame_len_q  <= frame_len_n;
			assembling_q <= assembling_n;
			exp_seq_q    <= exp_seq_n;
			in_frag_q    <= in_frag_n;
			act_q        <= act_n;
			pay_cnt_q    <= pay_cnt_n;
			end_seen_q   <= end_seen_n;
			ovf_q        <= ovf_n;
		end
	end

endmodule
`default_nettype wire

// ===== design/fragment_reassembler.sv =====
// Fragment reassembler.
// Input channel item/item_valid/item_stall carries one operation per transfer:
// push a fragment byte, read back a frame byte by index, or reset the
// reassembler. The first pushed byte of a fragment is its header (start flag
// bit 7, end flag bit 6, sequence in bits 5..0); the rest is payload, written
// into the frame store as it arrives while the fragment is accepted and fits.
// Output channel result/result_valid/result_stall returns one transfer for a
// read and one at the last byte of each fragment (complete, incomplete or
// error). Other operations return nothing.
// Throughput: one operation per cycle while item_stall is low. A result passes
// through the read stage, registered with the store read, and then the output
// register before it is shown.
// Reset (arst_n low) clears the control state and empties the pipeline; the
// store contents are not cleared and no clearing pass is needed.
// When the receiver stalls, the output register holds its result and one more
// result is held in the read stage; input is stalled only when both are full.
`default_nettype none
module fragment_reassembler
	import frs_pkg::*;
#(
	parameter int MAX_FRAME   = FRS_MAX_FRAME,
	parameter int SEQ_MODULUS = FRS_SEQ_MODULUS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t item,
	input  wire logic     item_valid,
	output logic          item_stall,
	output out_item_t     result,
	output logic          result_valid,
	input  wire logic     result_stall
);

	localparam int AW = $clog2(MAX_FRAME);

	logic          accept;
	logic          adv;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [7:0]    rd_data;
	res_t          res;

	logic          valid_s1;
	logic [1:0]    status_s1;
	logic [9:0]    size_s1;
	logic          rd_zero_s1;

	assign adv        = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;
	assign rd_en      = res.valid && (res.status == ST_READ);

	frs_ctrl #(
		.MAX_FRAME   (MAX_FRAME),
		.SEQ_MODULUS (SEQ_MODULUS),
		.AW          (AW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.res     (res)
	);

	frs_frame_buf #(
		.DEPTH (MAX_FRAME),
		.AW    (AW)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (AW'(item.read_index)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= res.valid;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= res.status;
			size_s1    <= res.total_len;
			rd_zero_s1 <= res.rd_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.status    <= status_s1;
			result.total_len <= size_s1;
			result.read_data <= (status_s1 == ST_READ && !rd_zero_s1) ? rd_data : 8'd0;
		end
	end

	a_reset_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.func == FUNC_RESET |=> !valid_s1)
		else $error("reset operation produced a result");

	a_read_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_READ |-> result.total_len == 10'd0)
		else $error("read reply carries a frame size");

	a_data_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_READ |-> result.read_data == 8'd0)
		else $error("fragment verdict carries read data");

endmodule
`default_nettype wire

// ===== sim/reassembly_checker.sv =====
module reassembly_checker
	import frs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire in_item_t            item,
	input  wire logic                item_valid,
	input  wire logic                item_stall,
	input  wire out_item_t           result,
	input  wire logic                result_valid,
	input  wire logic                result_stall,
	output int unsigned              fail_count,
	output int unsigned              pending,
	output logic [FRS_MAX_FRAME-1:0] written,
	output int unsigned              n_complete,
	output int unsigned              n_incomplete,
	output int unsigned              n_error,
	output int unsigned              n_read
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]               frame_copy [FRS_MAX_FRAME];
	logic [FRS_MAX_FRAME-1:0] copy_valid;
	logic [9:0]               frame_len;
	logic                     assembling;
	logic [SEQ_W-1:0]         want_seq;
	logic                     in_frag;
	act_t                     frag_act;
	logic [9:0]               frag_bytes;
	logic                     end_flag;
	logic                     overflow;
	out_item_t                awaited [$];
	int unsigned              mismatches;
	int unsigned              tally [4];

	task automatic drop_frame();
		frame_len = '0;
		assembling = 1'b0;
		want_seq = '0;
	endtask

	task automatic clear_control();
		drop_frame();
		in_frag = 1'b0;
		frag_act = ACT_IDLE;
		frag_bytes = '0;
		end_flag = 1'b0;
		overflow = 1'b0;
	endtask

	task automatic await_result(input logic [1:0] st, input logic [9:0] size,
			input logic [7:0] data);
		out_item_t r;
		r.status = st;
		r.total_len = size;
		r.read_data = data;
		awaited.push_back(r);
	endtask

	task automatic predict(input in_item_t it);
		logic [10:0] pos;
		logic [SEQ_W-1:0] seq;
		seq = it.data_byte[SEQ_W-1:0];
		case (it.func)
		FUNC_READ: begin
			if (it.read_index < FRS_MAX_FRAME)
				await_result(ST_READ, '0, frame_copy[it.read_index]);
			else
				await_result(ST_READ, '0, '0);
		end
		FUNC_RESET: clear_control();
		FUNC_PUSH: begin
			if (!in_frag) begin
				if (it.fragment_last) begin
					// header with nothing behind it
					drop_frame();
					await_result(ST_ERROR, '0, '0);
				end else begin
					if ((it.data_byte & HDR_START) != '0) begin
						drop_frame();
						if (seq != '0) begin
							frag_act = ACT_REJECT;
						end else begin
							assembling = 1'b1;
							frag_act = ACT_ACCEPT;
						end
					end else if (!assembling) begin
						frag_act = ACT_REJECT;
					end else if (seq != want_seq) begin
						drop_frame();
						frag_act = ACT_REJECT;
					end else begin
						frag_act = ACT_ACCEPT;
					end
					in_frag = 1'b1;
					end_flag = (it.data_byte & HDR_END) != '0;
					frag_bytes = '0;
					overflow = 1'b0;
				end
			end else begin
				if (frag_act == ACT_ACCEPT && !overflow) begin
					pos = {1'b0, frame_len} + {1'b0, frag_bytes};
					if (pos < FRS_MAX_FRAME) begin
						frame_copy[pos[8:0]] = it.data_byte;
						copy_valid[pos[8:0]] = 1'b1;
						frag_bytes = frag_bytes + 10'd1;
					end else begin
						overflow = 1'b1;
					end
				end
				if (it.fragment_last) begin
					in_frag = 1'b0;
					if (frag_act != ACT_ACCEPT || overflow) begin
						if (frag_act == ACT_ACCEPT)
							drop_frame();
						frag_act = ACT_IDLE;
						await_result(ST_ERROR, '0, '0);
					end else begin
						frag_act = ACT_IDLE;
						frame_len = frame_len + frag_bytes;
						want_seq = (want_seq == SEQ_W'(FRS_SEQ_MODULUS - 1)) ?
							'0 : want_seq + SEQ_W'(1);
						if (end_flag) begin
							assembling = 1'b0;
							await_result(ST_COMPLETE, frame_len, '0);
						end else begin
							await_result(ST_INCOMPLETE, '0, '0);
						end
					end
				end
			end
		end
		default: ;
		endcase
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result status %0d size %0d data %02h",
					$time, got.status, got.total_len, got.read_data);
		end else begin
			want = awaited.pop_front();
			tally[want.status]++;
			if (got.status !== want.status || got.total_len !== want.total_len ||
					got.read_data !== want.read_data) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected status %0d size %0d data %02h,",
						$time, want.status, want.total_len, want.read_data,
						" got status %0d size %0d data %02h",
						got.status, got.total_len, got.read_data);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_control();
			copy_valid = '0;
			awaited.delete();
		end else begin
			// results of this edge can never belong to the item taken at it
			if (result_valid && !result_stall)
				check_result(result);
			if (item_valid && !item_stall)
				predict(item);
		end
		written <= copy_valid;
		pending <= awaited.size();
		fail_count <= mismatches;
		n_complete <= tally[ST_COMPLETE];
		n_incomplete <= tally[ST_INCOMPLETE];
		n_error <= tally[ST_ERROR];
		n_read <= tally[ST_READ];
	end

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import frs_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned RUN_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES = 300;

	logic      clk = 1'b0;
	logic      arst_n;
	in_item_t  item;
	logic      item_valid;
	logic      item_stall;
	out_item_t result;
	logic      result_valid;
	logic      result_stall = 1'b0;

	int unsigned              fail_count;
	int unsigned              pending;
	logic [FRS_MAX_FRAME-1:0] written;
	int unsigned              n_complete, n_incomplete, n_error, n_read;

	int unsigned cycles;
	int unsigned n_sent;
	bit          tx_quiet;
	logic        rx_quiet = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_prev = 1'b0;
	int unsigned stall_left;
	int unsigned rx_roll;

	fragment_reassembler u_top (
		.clk,
		.arst_n,
		.item,
		.item_valid,
		.item_stall,
		.result,
		.result_valid,
		.result_stall
	);

	reassembly_checker u_checker (
		.clk,
		.arst_n,
		.item,
		.item_valid,
		.item_stall,
		.result,
		.result_valid,
		.result_stall,
		.fail_count,
		.pending,
		.written,
		.n_complete,
		.n_incomplete,
		.n_error,
		.n_read
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("timeout with %0d results outstanding", pending);
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls, a long hold-off on request
	always @(posedge clk) begin
		hold_prev <= hold_req;
		if (hold_req && !hold_prev) begin
			stall_left <= HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (rx_quiet) begin
			result_stall <= 1'b0;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 55) begin
				result_stall <= 1'b0;
			end else if (rx_roll < 93) begin
				result_stall <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				result_stall <= 1'b1;
				stall_left <= $urandom_range(8, 30);
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one item, hold it until the transfer, then maybe idle
	task automatic xfer(input logic [1:0] fn, input logic [7:0] b, input logic lst,
			input logic [8:0] idx);
		in_item_t it;
		int unsigned g;
		it.func = fn;
		it.data_byte = b;
		it.fragment_last = lst;
		it.read_index = idx;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		n_sent++;
		g = tx_quiet ? 0 : pick_gap();
		if (g != 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic lst);
		xfer(FUNC_PUSH, b, lst, 9'($urandom_range(0, FRS_MAX_FRAME - 1)));
	endtask

	task automatic send_fragment(input logic [7:0] hdr, input int unsigned len);
		int unsigned i;
		push_byte(hdr, len == 0);
		for (i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	// read back a byte that has been assembled at some point
	task automatic read_back();
		int unsigned start;
		int unsigned k;
		logic [8:0] idx;
		bit found;
		start = $urandom_range(0, FRS_MAX_FRAME - 1);
		found = 1'b0;
		for (k = 0; k < FRS_MAX_FRAME && !found; k++) begin
			idx = 9'((start + k) % FRS_MAX_FRAME);
			if (written[idx])
				found = 1'b1;
		end
		if (found)
			xfer(FUNC_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
	endtask

	task automatic send_frame(input int unsigned nfrag, input int unsigned maxlen);
		int unsigned f;
		logic [7:0] hdr;
		for (f = 0; f < nfrag; f++) begin
			hdr = 8'(f % FRS_SEQ_MODULUS);
			if (f == 0)
				hdr = hdr | HDR_START;
			if (f == nfrag - 1)
				hdr = hdr | HDR_END;
			send_fragment(hdr, $urandom_range(1, maxlen));
			if ($urandom_range(0, 7) == 0)
				read_back();
		end
	endtask

	task automatic random_scenario();
		int unsigned r;
		int unsigned n;
		logic [7:0] hdr;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			send_frame($urandom_range(1, 4), 8);
		end else if (r < 70) begin
			repeat ($urandom_range(1, 4)) read_back();
		end else if (r < 85) begin
			hdr = $urandom_range(0, 1) ? HDR_END : 8'h00;
			case ($urandom_range(0, 4))
			0: begin
				// open a frame, then continue with the wrong sequence
				send_fragment(HDR_START, $urandom_range(1, 6));
				hdr = hdr | ($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(2, 63)));
				send_fragment(hdr, $urandom_range(1, 6));
			end
			1: send_fragment(HDR_START | hdr | 8'($urandom_range(1, 63)),
				$urandom_range(1, 6));
			2: begin
				xfer(FUNC_RESET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					9'($urandom_range(0, FRS_MAX_FRAME - 1)));
				send_fragment(hdr | 8'($urandom_range(0, 63)), $urandom_range(1, 6));
			end
			3: send_fragment(8'($urandom_range(0, 255)), 0);
			default: begin
				// abandon a fragment halfway
				push_byte(HDR_START, 1'b0);
				repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
				xfer(FUNC_RESET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					9'($urandom_range(0, FRS_MAX_FRAME - 1)));
			end
			endcase
		end else if (r < 95) begin
			n = $urandom_range(0, 5);
			repeat (n) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			push_byte(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			xfer($urandom_range(0, 1) ? FUNC_RESET : FUNC_UNUSED,
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				9'($urandom_range(0, FRS_MAX_FRAME - 1)));
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned f;
		logic [7:0] hdr;
		arst_n <= 1'b0;
		item <= '0;
		item_valid <= 1'b0;
		tx_quiet = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases
		push_byte(HDR_START, 1'b1);
		push_byte(HDR_START | HDR_END, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hA5, 1'b1);
		xfer(FUNC_READ, 8'h00, 1'b0, 9'd0);
		xfer(FUNC_READ, 8'hFF, 1'b1, 9'd2);
		push_byte(HDR_START | 8'h3F, 1'b0);
		push_byte(8'h11, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h22, 1'b1);
		push_byte(HDR_START, 1'b0);
		push_byte(8'h33, 1'b0);
		push_byte(8'h44, 1'b1);
		push_byte(8'h05, 1'b0);
		push_byte(8'h55, 1'b1);
		push_byte(HDR_START, 1'b0);
		push_byte(8'h66, 1'b1);
		push_byte(HDR_END | 8'h01, 1'b0);
		push_byte(8'h77, 1'b1);
		push_byte(HDR_START, 1'b0);
		push_byte(8'h88, 1'b0);
		xfer(FUNC_RESET, 8'hFF, 1'b1, 9'h1FF);
		xfer(FUNC_UNUSED, 8'h00, 1'b0, 9'd0);
		drain();

		while (n_sent < 300)
			random_scenario();

		// full-size frame whose sequence runs past the wrap: 8 + 72 * 7 bytes
		send_fragment(HDR_START, 8);
		for (f = 1; f <= 72; f++) begin
			hdr = 8'(f % FRS_SEQ_MODULUS);
			if (f == 72)
				hdr = hdr | HDR_END;
			send_fragment(hdr, 7);
		end
		drain();

		// hold the receiver off while items keep coming
		tx_quiet = 1'b1;
		hold_req <= 1'b1;
		repeat (12) begin
			read_back();
			read_back();
			send_frame(1, 3);
		end
		hold_req <= 1'b0;

		rx_quiet <= 1'b1;
		while (n_sent < 1000)
			random_scenario();
		rx_quiet <= 1'b0;
		tx_quiet = 1'b0;

		// single fragment that runs past the end of the store
		send_fragment(HDR_START | HDR_END, FRS_MAX_FRAME + 3);

		while (n_sent < 1550) begin
			tx_quiet = $urandom_range(0, 3) == 0;
			rx_quiet <= $urandom_range(0, 3) == 0;
			random_scenario();
		end
		rx_quiet <= 1'b0;

		drain();
		repeat (20) @(posedge clk);

		$display("%0d transfers in: %0d complete, %0d incomplete,", n_sent, n_complete,
			n_incomplete, " %0d error, %0d read results", n_error, n_read);
		$display("covered sequence wrap, a %0d-byte frame, overflow and receiver hold-off",
			FRS_MAX_FRAME);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/frs_pkg.sv
design/frs_frame_buf.sv
design/frs_ctrl.sv
design/fragment_reassembler.sv
sim/reassembly_checker.sv
sim/testbench.sv
